[sv/rkss_pkg.sv]
// Package for the row k-th smallest selector: field widths, register
// indexes, the cell control struct and the signed ordering key.
// No dependencies.
package rkss_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_LEN_W  = 7;
  localparam int RANK_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK       = 1'b1;

  localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RST = 7'd64;
  localparam logic [RANK_W-1:0]    RANK_RST       = 6'd0;

  typedef struct packed {
    logic ins_en;
    logic occupied;
  } cell_ctl_t;

  // Flipping the sign bit orders two's complement values as unsigned keys.
  function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
    order_key = {~v[DATA_W-1], v[DATA_W-2:0]};
  endfunction

endpackage

[sv/row_kth_smallest_select.sv]
// The result of a row is registered and strobed in the cycle after its last element.
// Throughput: one element per cycle; busy stays low and rows follow back to back.
// The rank is read from a chain of MAX_COLS insertion cells kept in ascending order.
// Reset (rst_n low, synchronous) clears the element count and the result strobe
// and sets row_length to 64 and rank to 0; cell contents are not reset.
// Results cannot be held off by the receiver.
module row_kth_smallest_select
  import rkss_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                   out_valid,
  output logic signed [DATA_W-1:0] out_kth_value,
  output logic                   out_rank_error,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int IDX_W = $clog2(MAX_COLS);
  localparam int LEN_W = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;

  logic [CFG_LEN_W-1:0] row_length_r;
  logic [RANK_W-1:0]    rank_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_kth_value_r;
  logic                 out_rank_error_r;

  logic [LEN_W-1:0]  len_ext;
  logic [LEN_W-1:0]  eff_len;
  logic [CNT_W-1:0]  row_len;
  logic [LEN_W-1:0]  rank_ext;
  logic [IDX_W-1:0]  sel_idx;
  logic              accept;
  logic              flush;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  cnt_inc;
  logic              row_done;
  logic              rank_bad;

  logic              cell_shift [MAX_COLS];
  logic [DATA_W-1:0] cell_val   [MAX_COLS];
  logic [DATA_W-1:0] cell_nxt   [MAX_COLS];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    len_ext = LEN_W'(row_length_r);
    eff_len = len_ext;
    if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LEN_W'(MAX_COLS)) begin
      eff_len = LEN_W'(MAX_COLS);
    end
  end

  assign row_len  = eff_len[CNT_W-1:0];
  assign rank_ext = LEN_W'(rank_r);
  assign sel_idx  = rank_ext[IDX_W-1:0];
  assign rank_bad = rank_ext >= eff_len;

  assign flush    = cnt_r >= row_len;
  assign base     = flush ? '0 : cnt_r;
  assign cnt_inc  = base + CNT_W'(1);
  assign row_done = cnt_inc == row_len;
  assign cnt_nxt  = row_done ? '0 : cnt_inc;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] left_value;
    logic              left_shift;

    assign ctl.ins_en   = accept;
    assign ctl.occupied = CNT_W'(i) < base;

    if (i == 0) begin : g_head
      assign left_value = $unsigned(in_value);
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left_value = cell_val[i-1];
      assign left_shift = cell_shift[i-1];
    end

    rkss_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  ($unsigned(in_value)),
      .left_value (left_value),
      .left_shift (left_shift),
      .shift      (cell_shift[i]),
      .value_r    (cell_val[i]),
      .value_nxt  (cell_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      rank_r       <= RANK_RST;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_LENGTH: row_length_r <= cfg_wdata;
          CFG_RANK:       rank_r       <= cfg_wdata[RANK_W-1:0];
          default:        ;
        endcase
      end
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= accept && row_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_done) begin
      out_kth_value_r  <= rank_bad ? '0 : cell_nxt[sel_idx];
      out_rank_error_r <= rank_bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kth_value  = $signed(out_kth_value_r);
  assign out_rank_error = out_rank_error_r;

endmodule

[sv/rkss_cell.sv]
// One cell of the sorted insertion chain: holds one element of the row.
// Depends on rkss_pkg.
module rkss_cell
  import rkss_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] ins_value,
  input  logic [DATA_W-1:0] left_value,
  input  logic              left_shift,
  output logic              shift,
  output logic [DATA_W-1:0] value_r,
  output logic [DATA_W-1:0] value_nxt
);

  logic gt;

  assign gt    = ctl.occupied && (order_key(value_r) > order_key(ins_value));
  assign shift = !ctl.occupied || gt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins_en && shift) begin
      value_nxt = left_shift ? left_value : ins_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[sv/rkss_checker.sv]
// Port-level checks for row_kth_smallest_select, attached by a bind.
// Depends on rkss_pkg and on the top level's port names.
module rkss_checker
  import rkss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic signed [DATA_W-1:0] out_kth_value,
  input logic                   out_rank_error
);

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rank_error) |-> (out_kth_value == '0))
    else $error("A result with a rank error carries a nonzero value.");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("The block refused a transaction.");

  a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("A result appeared without a transaction in the cycle before.");

endmodule

bind row_kth_smallest_select rkss_checker u_rkss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_kth_value  (out_kth_value),
  .out_rank_error (out_rank_error)
);
